@@ design/hwt_pkg.sv @@
// Shared types, constants and state codes for the hashed timing wheel.
`default_nettype none
package hwt_pkg;

  localparam int SLOTS   = 64;
  localparam int TIMERS  = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ID_W    = $clog2(TIMERS);
  localparam int LINK_W  = ID_W + 1;
  localparam int ROT_W   = 24;
  localparam int DLY_W   = 24;
  localparam int IV_W    = 8;
  localparam int EV_W    = 16;
  localparam int ST_W    = 3;

  // Link value with the top bit set marks the end of a list.
  localparam logic [LINK_W-1:0] NIL = {1'b1, {ID_W{1'b0}}};

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    STS_SET_OK   = 3'd0,
    STS_SET_FULL = 3'd1,
    STS_EXPIRED  = 3'd2,
    STS_DELETED  = 3'd3,
    STS_DEL_BAD  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SET_HCHK,
    S_SET_NWR,
    S_DEL_REC,
    S_UL_HCHK,
    S_UL_PWR,
    S_UL_NCHK,
    S_UL_NWR,
    S_UL_CLR,
    S_TK_HEAD,
    S_TK_NEXT,
    S_TK_REC,
    S_TK_FIN
  } state_t;

  // One timer entry as kept in the timer memory.
  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
    logic [ROT_W-1:0]  rot;
    logic [SLOT_W-1:0] home;
    logic [EV_W-1:0]   ev;
  } timer_rec_t;

  typedef struct packed {
    logic             valid;
    logic [DLY_W-1:0] dividend;
    logic [IV_W-1:0]  divisor;
  } div_req_t;

endpackage
`default_nettype wire

@@ design/hwt_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module hwt_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire hwt_pkg::div_req_t      req,
  output logic                        done,
  output logic [hwt_pkg::DLY_W-1:0]   quot
);
  import hwt_pkg::*;

  localparam int CNT_W = $clog2(DLY_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DLY_W-1:0] q_r, q_nxt;
  logic [IV_W-1:0]  rem_r, rem_nxt;
  logic [IV_W-1:0]  dvs_r, dvs_nxt;
  logic [IV_W:0]    trial;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, q_r[DLY_W-1]};
    if (req.valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DLY_W);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in IV_W bits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = IV_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[DLY_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[IV_W-1:0];
        q_nxt   = {q_r[DLY_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

@@ design/hwt_timer_mem.sv @@
// Timer entry memory: one write port, one registered read port.
`default_nettype none
module hwt_timer_mem (
  input  wire                        clk,
  input  wire [hwt_pkg::ID_W-1:0]    rd_addr,
  output hwt_pkg::timer_rec_t        rd_data,
  input  wire                        we,
  input  wire [hwt_pkg::ID_W-1:0]    wr_addr,
  input  wire hwt_pkg::timer_rec_t   wr_data
);
  import hwt_pkg::*;

  timer_rec_t mem [TIMERS];
  timer_rec_t q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  assign rd_data = q_r;

endmodule
`default_nettype wire

@@ design/hwt_head_mem.sv @@
// Slot head memory; per-slot valid bits make unwritten slots read as empty.
`default_nettype none
module hwt_head_mem (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [hwt_pkg::SLOT_W-1:0]    rd_addr,
  output logic [hwt_pkg::LINK_W-1:0]   rd_data,
  input  wire                          we,
  input  wire [hwt_pkg::SLOT_W-1:0]    wr_addr,
  input  wire [hwt_pkg::LINK_W-1:0]    wr_data
);
  import hwt_pkg::*;

  logic [LINK_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  vld_r;
  logic [LINK_W-1:0] q_r;
  logic              qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  // valid bits and the registered valid of the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      qv_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = qv_r ? q_r : NIL;

endmodule
`default_nettype wire

@@ design/hashed_timing_wheel.sv @@
// Top level: hashed timing wheel with command interface and sequencer.
// Pool of 64 timers over 64 slots. An item is taken when start is high and
// busy is low; results come one per cycle on out_valid and cannot be held off.
// A set keeps busy high for the bit-serial divide of the delay by the tick
// interval, a head read, writes of the new entry and slot head and, if the
// slot held a timer, a write of the old head's prev link. A delete of an
// armed timer walks the unlink states; a delete of an unarmed id is answered
// at once, busy staying low. A tick walks the slot list through the one read
// port of the timer memory, unlinking each expiring timer; those are reported
// newest first. out_last marks the last result of an item. Each result shows
// in the cycle after its state, so the last one can appear after busy falls.
`default_nettype none
module hashed_timing_wheel (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [1:0]                    in_kind,
  input  wire [hwt_pkg::DLY_W-1:0]     in_delay_units,
  input  wire [hwt_pkg::EV_W-1:0]      in_event_tag,
  input  wire [hwt_pkg::ID_W-1:0]      in_timer_id,
  input  wire                          cfg_we,
  input  wire [hwt_pkg::IV_W-1:0]      cfg_wdata,
  output logic                         out_valid,
  output logic [hwt_pkg::ST_W-1:0]     out_status,
  output logic [hwt_pkg::ID_W-1:0]     out_result_id,
  output logic [hwt_pkg::EV_W-1:0]     out_result_event,
  output logic                         out_last
);
  import hwt_pkg::*;

  state_t            state_r, state_nxt;
  logic [IV_W-1:0]   interval_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [TIMERS-1:0] armed_r, armed_nxt;
  logic              mode_del_r, mode_del_nxt;
  logic [EV_W-1:0]   tag_r, tag_nxt;
  logic [ID_W-1:0]   t_r, t_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic [ROT_W-1:0]  rot_r, rot_nxt;
  timer_rec_t        trec_r, trec_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] nx_r, nx_nxt;
  logic              ishead_r, ishead_nxt;
  logic              pend_r, pend_nxt;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [EV_W-1:0]   pev_r, pev_nxt;

  logic              ov_r;
  logic [ST_W-1:0]   ost_r;
  logic [ID_W-1:0]   oid_r;
  logic [EV_W-1:0]   oev_r;
  logic              olast_r;

  logic              emit;
  status_t           e_st;
  logic [ID_W-1:0]   e_id;
  logic [EV_W-1:0]   e_ev;
  logic              e_last;

  logic [ID_W-1:0]   tm_raddr, tm_waddr;
  logic              tm_we;
  timer_rec_t        tm_q, tm_wdata;
  logic [SLOT_W-1:0] hm_raddr, hm_waddr;
  logic              hm_we;
  logic [LINK_W-1:0] hm_q, hm_wdata;

  div_req_t          dreq;
  logic              ddone;
  logic [DLY_W-1:0]  dquot;

  logic              accept;
  logic              full;
  logic [ID_W-1:0]   free_id;
  logic [DLY_W-1:0]  ticks;
  logic              is_head;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // lowest free timer id
  always_comb begin
    free_id = '0;
    full    = 1'b1;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!armed_r[i]) begin
        free_id = ID_W'(i);
        full    = 1'b0;
      end
    end
  end

  assign ticks   = (dquot == '0) ? DLY_W'(1) : dquot;
  assign is_head = (hm_q == {1'b0, t_r});

  // divider request on a set item
  always_comb begin
    dreq.valid    = accept && (in_kind == KIND_SET);
    dreq.dividend = in_delay_units;
    dreq.divisor  = (interval_r == '0) ? IV_W'(1) : interval_r;
  end

  hwt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .quot  (dquot)
  );

  hwt_timer_mem u_tmem (
    .clk     (clk),
    .rd_addr (tm_raddr),
    .rd_data (tm_q),
    .we      (tm_we),
    .wr_addr (tm_waddr),
    .wr_data (tm_wdata)
  );

  hwt_head_mem u_hmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (hm_raddr),
    .rd_data (hm_q),
    .we      (hm_we),
    .wr_addr (hm_waddr),
    .wr_data (hm_wdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_SET:  state_nxt = S_DIV;
            KIND_DEL:  state_nxt = armed_r[in_timer_id] ? S_DEL_REC : S_IDLE;
            KIND_TICK: state_nxt = S_TK_HEAD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (ddone) begin
          state_nxt = full ? S_IDLE : S_SET_HCHK;
        end
      end
      S_SET_HCHK: state_nxt = hm_q[LINK_W-1] ? S_IDLE : S_SET_NWR;
      S_SET_NWR:  state_nxt = S_IDLE;
      S_DEL_REC:  state_nxt = S_UL_HCHK;
      S_UL_HCHK: begin
        if (!is_head && !trec_r.prev[LINK_W-1]) begin
          state_nxt = S_UL_PWR;
        end else begin
          state_nxt = S_UL_NCHK;
        end
      end
      S_UL_PWR:  state_nxt = S_UL_NCHK;
      S_UL_NCHK: state_nxt = trec_r.next[LINK_W-1] ? S_UL_CLR : S_UL_NWR;
      S_UL_NWR:  state_nxt = S_UL_CLR;
      S_UL_CLR:  state_nxt = mode_del_r ? S_IDLE : S_TK_NEXT;
      S_TK_HEAD: state_nxt = S_TK_NEXT;
      S_TK_NEXT: state_nxt = cur_r[LINK_W-1] ? S_TK_FIN : S_TK_REC;
      S_TK_REC:  state_nxt = (tm_q.rot != '0) ? S_TK_NEXT : S_UL_HCHK;
      S_TK_FIN:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory controls and results
  always_comb begin
    slot_nxt     = slot_r;
    armed_nxt    = armed_r;
    mode_del_nxt = mode_del_r;
    tag_nxt      = tag_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    rot_nxt      = rot_r;
    trec_nxt     = trec_r;
    cur_nxt      = cur_r;
    nx_nxt       = nx_r;
    ishead_nxt   = ishead_r;
    pend_nxt     = pend_r;
    pid_nxt      = pid_r;
    pev_nxt      = pev_r;
    tm_raddr     = t_r;
    tm_we        = 1'b0;
    tm_waddr     = t_r;
    tm_wdata     = trec_r;
    hm_raddr     = s_r;
    hm_we        = 1'b0;
    hm_waddr     = s_r;
    hm_wdata     = NIL;
    emit         = 1'b0;
    e_st         = STS_SET_OK;
    e_id         = '0;
    e_ev         = '0;
    e_last       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        tag_nxt  = in_event_tag;
        t_nxt    = in_timer_id;
        tm_raddr = in_timer_id;
        hm_raddr = slot_r;
        if (accept) begin
          unique case (in_kind)
            KIND_DEL: begin
              mode_del_nxt = 1'b1;
              if (!armed_r[in_timer_id]) begin
                emit = 1'b1;
                e_st = STS_DEL_BAD;
                e_id = in_timer_id;
              end
            end
            KIND_TICK: begin
              mode_del_nxt = 1'b0;
              pend_nxt     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (ddone) begin
          if (full) begin
            emit = 1'b1;
            e_st = STS_SET_FULL;
          end else begin
            t_nxt    = free_id;
            s_nxt    = slot_r + ticks[SLOT_W-1:0];
            hm_raddr = slot_r + ticks[SLOT_W-1:0];
            rot_nxt  = ROT_W'(ticks >> SLOT_W);
          end
        end
      end
      S_SET_HCHK: begin
        tm_we         = 1'b1;
        tm_waddr      = t_r;
        tm_wdata.next = hm_q;
        tm_wdata.prev = NIL;
        tm_wdata.rot  = rot_r;
        tm_wdata.home = s_r;
        tm_wdata.ev   = tag_r;
        hm_we         = 1'b1;
        hm_waddr      = s_r;
        hm_wdata      = {1'b0, t_r};
        armed_nxt[t_r] = 1'b1;
        emit          = 1'b1;
        e_st          = STS_SET_OK;
        e_id          = t_r;
        e_ev          = tag_r;
        cur_nxt       = hm_q;
        tm_raddr      = hm_q[ID_W-1:0];
      end
      S_SET_NWR: begin
        tm_we         = 1'b1;
        tm_waddr      = cur_r[ID_W-1:0];
        tm_wdata      = tm_q;
        tm_wdata.prev = {1'b0, t_r};
      end
      S_DEL_REC: begin
        trec_nxt = tm_q;
        hm_raddr = tm_q.home;
      end
      S_UL_HCHK: begin
        ishead_nxt = is_head;
        tm_raddr   = trec_r.prev[ID_W-1:0];
        if (is_head) begin
          hm_we    = 1'b1;
          hm_waddr = trec_r.home;
          hm_wdata = trec_r.next;
        end
      end
      S_UL_PWR: begin
        tm_we         = 1'b1;
        tm_waddr      = trec_r.prev[ID_W-1:0];
        tm_wdata      = tm_q;
        tm_wdata.next = trec_r.next;
      end
      S_UL_NCHK: begin
        tm_raddr = trec_r.next[ID_W-1:0];
      end
      S_UL_NWR: begin
        tm_we         = 1'b1;
        tm_waddr      = trec_r.next[ID_W-1:0];
        tm_wdata      = tm_q;
        tm_wdata.prev = ishead_r ? NIL : trec_r.prev;
      end
      S_UL_CLR: begin
        tm_we          = 1'b1;
        tm_waddr       = t_r;
        tm_wdata       = trec_r;
        tm_wdata.next  = NIL;
        tm_wdata.prev  = NIL;
        armed_nxt[t_r] = 1'b0;
        cur_nxt        = nx_r;
        if (mode_del_r) begin
          emit = 1'b1;
          e_st = STS_DELETED;
          e_id = t_r;
          e_ev = trec_r.ev;
        end
      end
      S_TK_HEAD: begin
        cur_nxt = hm_q;
      end
      S_TK_NEXT: begin
        tm_raddr = cur_r[ID_W-1:0];
      end
      S_TK_REC: begin
        nx_nxt = tm_q.next;
        if (tm_q.rot != '0) begin
          tm_we        = 1'b1;
          tm_waddr     = cur_r[ID_W-1:0];
          tm_wdata     = tm_q;
          tm_wdata.rot = tm_q.rot - ROT_W'(1);
          cur_nxt      = tm_q.next;
        end else begin
          // report the previous expiry now that another follows it
          if (pend_r) begin
            emit   = 1'b1;
            e_st   = STS_EXPIRED;
            e_id   = pid_r;
            e_ev   = pev_r;
            e_last = 1'b0;
          end
          pend_nxt = 1'b1;
          pid_nxt  = cur_r[ID_W-1:0];
          pev_nxt  = tm_q.ev;
          t_nxt    = cur_r[ID_W-1:0];
          trec_nxt = tm_q;
          hm_raddr = tm_q.home;
        end
      end
      S_TK_FIN: begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (pend_r) begin
          emit = 1'b1;
          e_st = STS_EXPIRED;
          e_id = pid_r;
          e_ev = pev_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      interval_r <= IV_W'(10);
      slot_r     <= '0;
      armed_r    <= '0;
      pend_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      slot_r  <= slot_nxt;
      armed_r <= armed_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_del_r <= mode_del_nxt;
    tag_r      <= tag_nxt;
    t_r        <= t_nxt;
    s_r        <= s_nxt;
    rot_r      <= rot_nxt;
    trec_r     <= trec_nxt;
    cur_r      <= cur_nxt;
    nx_r       <= nx_nxt;
    ishead_r   <= ishead_nxt;
    pid_r      <= pid_nxt;
    pev_r      <= pev_nxt;
    ost_r      <= e_st;
    oid_r      <= e_id;
    oev_r      <= e_ev;
    olast_r    <= e_last;
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_result_id    = oid_r;
  assign out_result_event = oev_r;
  assign out_last         = olast_r;

endmodule
`default_nettype wire
